@@ hw/rtl/cafb_pkg.sv @@
// Shared types, codes and the filter sequence table of the CAN adapter frame bridge.
`timescale 1ns / 1ps
`default_nettype none
package cafb_pkg;

  localparam logic [7:0] HOST_SOF     = 8'hf1;
  localparam logic [7:0] CMD_INIT     = 8'hfa;
  localparam logic [7:0] CMD_FILTER   = 8'hfb;
  localparam logic [7:0] CMD_SEND     = 8'hfc;
  localparam logic [7:0] TYPE_INIT    = 8'h50;
  localparam logic [7:0] TYPE_FILTER  = 8'h53;
  localparam logic [7:0] TYPE_SEND    = 8'h60;
  localparam logic [7:0] TYPE_RECV    = 8'h70;
  localparam logic [7:0] REPLY_SOF    = 8'hf2;
  localparam logic [7:0] REPLY_INIT   = 8'hf6;
  localparam logic [7:0] FILTER_MASK  = 8'h1c;
  localparam logic [7:0] DECOY        = 8'h42;
  localparam int unsigned RESULT_LIMIT = 34;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ID0,
    ST_ID1,
    ST_ID2,
    ST_FETCH,
    ST_PUT
  } state_t;

  typedef enum logic [2:0] {
    JOB_DROP_HOST,
    JOB_DROP_ADAPTER,
    JOB_INIT,
    JOB_FILTER,
    JOB_SEND,
    JOB_REPLY
  } job_t;

  typedef struct packed {
    logic       dropped;
    logic       to_host;
    logic [7:0] data;
  } result_t;

  // Fixed filter sequence; the ID bytes replace the entries at 2, 3, 22 and 23.
  function automatic logic [7:0] filter_byte(input logic [5:0] k, input logic [7:0] hi,
                                             input logic [7:0] lo);
    logic [7:0] b;
    begin
      case (k)
        6'd0: b = TYPE_FILTER;
        6'd1: b = 8'h20;
        6'd2, 6'd22: b = hi;
        6'd3, 6'd23: b = lo;
        6'd6, 6'd10, 6'd14, 6'd26, 6'd29, 6'd30: b = 8'hff;
        6'd7, 6'd11, 6'd15, 6'd27, 6'd31: b = FILTER_MASK;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/can_adapter_frame_bridge.sv @@
// Top level of the CAN adapter frame bridge: frame parsing, buffer memory and reply sequencer.
`timescale 1ns / 1ps
`default_nettype none
// A byte that completes no frame is taken while idle, and the next byte may follow at once.
// A completing byte starts buffer reads for the ID bytes (ST_ID0, ST_ID1, ST_ID2), then per
// result byte a memory read (ST_FETCH, not for the first) and an output register load (ST_PUT),
// up to 34 result bytes. The buffer memory has one registered read port, which sets that pace.
// Reset (rst, synchronous) clears the frame state, the buffer valid bits and the decoy flag.
module can_adapter_frame_bridge #(
  parameter int MAX_MSG = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // data_byte
  input  wire logic       s_axis_tuser,   // action
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [1:0]      m_axis_tuser,   // frame_dropped, to_host
  output logic            m_axis_tlast,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data
);

  localparam int DEPTH = 2 * MAX_MSG;
  localparam int AW = $clog2(DEPTH);
  localparam logic [7:0] MAXB = 8'(MAX_MSG);
  localparam logic [7:0] LIMB = 8'(cafb_pkg::RESULT_LIMIT);

  logic decoy_enable;
  cafb_pkg::phase_t host_phase, adapter_phase;
  logic [7:0] host_command, host_length, host_count;
  logic [7:0] adapter_type, adapter_length, adapter_count;

  logic [7:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0] rdata;
  logic rvalid, we;
  logic [AW-1:0] raddr, waddr;
  logic [7:0] rd;

  cafb_pkg::state_t state, state_next;
  cafb_pkg::job_t job, job_next;
  logic job_dec;
  logic [7:0] job_len, job_type, job_len_next, job_type_next;
  logic [5:0] n, n_next, k;
  logic [7:0] id0, id1;
  logic done, accept;
  logic [7:0] b, flen, m, n8;
  cafb_pkg::result_t res;
  logic [7:0] pidx, base, idoff;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == cafb_pkg::ST_IDLE);
  assign b = s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoy_enable <= 1'b0;
    end else if (cfg_we) begin
      decoy_enable <= cfg_data;
    end
  end

  // Frame parsing on accepted bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      host_phase <= cafb_pkg::PH_IDLE;
      host_command <= '0;
      host_length <= '0;
      host_count <= '0;
      adapter_phase <= cafb_pkg::PH_IDLE;
      adapter_type <= '0;
      adapter_length <= '0;
      adapter_count <= '0;
    end else if (accept) begin
      if (!s_axis_tuser) begin
        case (host_phase)
          cafb_pkg::PH_IDLE: begin
            if (b == cafb_pkg::HOST_SOF) host_phase <= cafb_pkg::PH_CMD;
          end
          cafb_pkg::PH_CMD: begin
            host_command <= b;
            host_phase <= cafb_pkg::PH_LEN;
          end
          cafb_pkg::PH_LEN: begin
            host_length <= b;
            host_count <= '0;
            host_phase <= (b == 8'd0) ? cafb_pkg::PH_IDLE : cafb_pkg::PH_DATA;
          end
          default: begin
            host_count <= host_count + 8'd1;
            if (host_count + 8'd1 == host_length) host_phase <= cafb_pkg::PH_IDLE;
          end
        endcase
      end else begin
        case (adapter_phase)
          cafb_pkg::PH_IDLE: begin
            adapter_type <= b;
            adapter_phase <= cafb_pkg::PH_LEN;
          end
          cafb_pkg::PH_LEN: begin
            adapter_length <= b;
            adapter_count <= '0;
            adapter_phase <= (b == 8'd0) ? cafb_pkg::PH_IDLE : cafb_pkg::PH_DATA;
          end
          default: begin
            adapter_count <= adapter_count + 8'd1;
            if (adapter_count + 8'd1 == adapter_length) adapter_phase <= cafb_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Buffer store: host buffer in the lower half, adapter buffer in the upper half.
  always_comb begin
    we = 1'b0;
    waddr = '0;
    if (accept) begin
      if (!s_axis_tuser) begin
        we = (host_phase == cafb_pkg::PH_DATA) && (host_length <= MAXB);
        waddr = host_count[AW-1:0];
      end else begin
        we = (adapter_phase == cafb_pkg::PH_DATA) && (adapter_length <= MAXB);
        waddr = AW'(adapter_count + MAXB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= b;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      rvalid <= vld[raddr];
    end
  end

  assign rd = rvalid ? rdata : 8'd0;

  // Frame completion, the job it starts and the number of result bytes it causes.
  always_comb begin
    done = 1'b0;
    flen = 8'd0;
    if (!s_axis_tuser) begin
      if (host_phase == cafb_pkg::PH_LEN && b == 8'd0) done = 1'b1;
      if (host_phase == cafb_pkg::PH_DATA && host_count + 8'd1 == host_length) done = 1'b1;
      flen = (host_phase == cafb_pkg::PH_LEN) ? b : host_length;
    end else begin
      if (adapter_phase == cafb_pkg::PH_LEN && b == 8'd0) done = 1'b1;
      if (adapter_phase == cafb_pkg::PH_DATA && adapter_count + 8'd1 == adapter_length) begin
        done = 1'b1;
      end
      flen = (adapter_phase == cafb_pkg::PH_LEN) ? b : adapter_length;
    end
    m = (flen > MAXB) ? MAXB : flen;
    job_len_next = flen;
    job_type_next = adapter_type;
    n8 = 8'd0;
    job_next = cafb_pkg::JOB_REPLY;
    if (!s_axis_tuser) begin
      if (flen > MAXB) begin
        job_next = cafb_pkg::JOB_DROP_HOST;
        n8 = 8'd1;
      end else begin
        case (host_command)
          cafb_pkg::CMD_INIT: begin
            job_next = cafb_pkg::JOB_INIT;
            n8 = 8'd5 + {7'd0, decoy_enable};
          end
          cafb_pkg::CMD_FILTER: begin
            job_next = cafb_pkg::JOB_FILTER;
            n8 = LIMB;
          end
          cafb_pkg::CMD_SEND: begin
            job_next = cafb_pkg::JOB_SEND;
            n8 = 8'd6 + ((m > 8'd2) ? m - 8'd2 : 8'd0);
          end
          default: n8 = 8'd0;
        endcase
      end
    end else begin
      if (flen > MAXB) begin
        job_next = cafb_pkg::JOB_DROP_ADAPTER;
        n8 = 8'd1;
      end else if (adapter_type == cafb_pkg::TYPE_INIT) begin
        n8 = 8'd3 + {7'd0, decoy_enable};
      end else if (adapter_type == cafb_pkg::TYPE_RECV) begin
        n8 = 8'd5 + {7'd0, decoy_enable} + ((m > 8'd4) ? m - 8'd4 : 8'd0);
      end else begin
        n8 = {7'd0, decoy_enable};
      end
    end
    n_next = (n8 > LIMB) ? 6'(LIMB) : n8[5:0];
  end

  // Read address: ID bytes first, then the payload byte for the current result.
  always_comb begin
    base = (job == cafb_pkg::JOB_REPLY) ? MAXB : 8'd0;
    idoff = (job == cafb_pkg::JOB_FILTER) ? 8'd8 : 8'd0;
    if (job == cafb_pkg::JOB_SEND) begin
      pidx = {2'd0, k} - 8'd4;
    end else begin
      pidx = {2'd0, k} - {7'd0, job_dec} - 8'd1;
    end
    if (pidx >= MAXB) pidx = 8'd0;
    case (state)
      cafb_pkg::ST_ID0: raddr = AW'(base + idoff);
      cafb_pkg::ST_ID1: raddr = AW'(base + idoff + 8'd1);
      default: raddr = AW'(base + pidx);
    endcase
  end

  // Result byte for index k.
  always_comb begin
    logic [5:0] j;
    j = k - {5'd0, job_dec};
    res = '{dropped: 1'b0, to_host: 1'b1, data: 8'd0};
    case (job)
      cafb_pkg::JOB_DROP_HOST: res = '{dropped: 1'b1, to_host: 1'b0, data: 8'd0};
      cafb_pkg::JOB_DROP_ADAPTER: res = '{dropped: 1'b1, to_host: 1'b1, data: 8'd0};
      cafb_pkg::JOB_FILTER: begin
        res.to_host = 1'b0;
        res.data = cafb_pkg::filter_byte(k, id0, {3'd0, id1[7:5], 2'd0});
      end
      cafb_pkg::JOB_SEND: begin
        res.to_host = 1'b0;
        case (k)
          6'd0: res.data = cafb_pkg::TYPE_SEND;
          6'd1: res.data = job_len + 8'd2;
          6'd2: res.data = id0;
          6'd3: res.data = {3'd0, id1[7:5], 2'd0};
          6'd4, 6'd5: res.data = 8'd0;
          default: res.data = rd;
        endcase
      end
      cafb_pkg::JOB_INIT: begin
        j = k - 6'd2 - {5'd0, job_dec};
        if (k == 6'd0) begin
          res = '{dropped: 1'b0, to_host: 1'b0, data: cafb_pkg::TYPE_INIT};
        end else if (k == 6'd1) begin
          res = '{dropped: 1'b0, to_host: 1'b0, data: 8'd0};
        end else if (job_dec && k == 6'd2) begin
          res.data = cafb_pkg::DECOY;
        end else begin
          case (j)
            6'd0: res.data = cafb_pkg::REPLY_SOF;
            6'd1: res.data = cafb_pkg::REPLY_INIT;
            default: res.data = 8'd0;
          endcase
        end
      end
      default: begin
        if (job_dec && k == 6'd0) begin
          res.data = cafb_pkg::DECOY;
        end else if (job_type == cafb_pkg::TYPE_INIT) begin
          case (j)
            6'd0: res.data = cafb_pkg::REPLY_SOF;
            6'd1: res.data = cafb_pkg::REPLY_INIT;
            default: res.data = 8'd0;
          endcase
        end else begin
          case (j)
            6'd0: res.data = cafb_pkg::REPLY_SOF;
            6'd1: res.data = cafb_pkg::CMD_SEND;
            6'd2: res.data = job_len - 8'd2;
            6'd3: res.data = id0 | {5'd0, id1[7:5]};
            6'd4: res.data = {id1[4:2], 5'd0};
            default: res.data = rd;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      cafb_pkg::ST_IDLE: begin
        if (accept && done && n_next != 6'd0) state_next = cafb_pkg::ST_ID0;
      end
      cafb_pkg::ST_ID0: state_next = cafb_pkg::ST_ID1;
      cafb_pkg::ST_ID1: state_next = cafb_pkg::ST_ID2;
      cafb_pkg::ST_ID2: state_next = cafb_pkg::ST_PUT;
      cafb_pkg::ST_FETCH: state_next = cafb_pkg::ST_PUT;
      cafb_pkg::ST_PUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = (k == n - 6'd1) ? cafb_pkg::ST_IDLE : cafb_pkg::ST_FETCH;
        end
      end
      default: state_next = cafb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cafb_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      k <= '0;
      n <= '0;
      job <= cafb_pkg::JOB_REPLY;
      job_dec <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cafb_pkg::ST_IDLE && accept && done) begin
        job <= job_next;
        n <= n_next;
        k <= '0;
        job_dec <= decoy_enable;
      end
      if (state == cafb_pkg::ST_PUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        k <= k + 6'd1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cafb_pkg::ST_IDLE && accept && done) begin
      job_len <= job_len_next;
      job_type <= job_type_next;
    end
    if (state == cafb_pkg::ST_ID1) id0 <= rd;
    if (state == cafb_pkg::ST_ID2) id1 <= rd;
    if (state == cafb_pkg::ST_PUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= res.data;
      m_axis_tuser <= {res.dropped, res.to_host};
      m_axis_tlast <= (k == n - 6'd1);
    end
  end

endmodule
`default_nettype wire
